// ===== rtl/core/vtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types and constants for the vertex transform and perspective divide.
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned PROD_W   = COORD_W + COEF_W;
	localparam int unsigned ACC_W    = PROD_W + 2;
	localparam int unsigned FRAC_SH  = 12;
	localparam int unsigned ROW_W    = 4 * COEF_W;
	localparam int unsigned QUOT_W   = COORD_W + 16;
	localparam int unsigned ROW_LAT  = 2;
	localparam int unsigned DIV_LAT  = QUOT_W + 2;
	localparam int unsigned TOTAL_LAT = ROW_LAT + DIV_LAT + 1;

	localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] MAX_S32 = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] MIN_S32 = 32'sh8000_0000;

	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;
	localparam logic [1:0] REG_ROW3 = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t [3:0] v;
		logic         sat;
		logic         div_en;
	} side_t;

endpackage

// ===== rtl/core/vertex_transform_perspective_divide.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 Q4.12 matrix times Q16.16 point, then divide by w.
// ----------------------------------------------------------------------------
// Fully pipelined: a new point is taken every cycle (busy is never raised)
// and its result appears on done after the four row multiply lanes, the
// bit-per-stage divider shared in shape by the three quotient lanes, and the
// output merge. The receiver cannot stall, so results are never held. Matrix
// rows are written through the cfg port, always ready; write them only while
// no point is in flight.
module vertex_transform_perspective_divide (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  vtpd_pkg::coord_t      in_x,
	input  vtpd_pkg::coord_t      in_y,
	input  vtpd_pkg::coord_t      in_z,
	input  vtpd_pkg::coord_t      in_w,
	output logic                  done,
	output vtpd_pkg::coord_t      out_x,
	output vtpd_pkg::coord_t      out_y,
	output vtpd_pkg::coord_t      out_z,
	output vtpd_pkg::coord_t      out_w,
	output logic                  divided,
	output logic                  saturated,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [vtpd_pkg::ROW_W-1:0] cfg_data
);
	import vtpd_pkg::*;

	logic [ROW_W-1:0] row_q [4];
	coord_t [3:0] p;
	coord_t [3:0] v;
	logic   [3:0] row_sat;
	coord_t [2:0] q;
	logic   [2:0] q_sat;
	logic [TOTAL_LAT-2:0] vld_q;
	side_t side_in;
	side_t side_q [DIV_LAT];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'h0000_0000_0000_1000;
			row_q[1] <= 64'h0000_0000_1000_0000;
			row_q[2] <= 64'h0000_1000_0000_0000;
			row_q[3] <= 64'h1000_0000_0000_0000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				REG_ROW3: row_q[3] <= cfg_data;
				default:  row_q[0] <= row_q[0];
			endcase
		end
	end

	assign p = {in_w, in_z, in_y, in_x};

	for (genvar r = 0; r < 4; r++) begin : g_row
		vtpd_row_lane u_row (
			.clk (clk),
			.row (row_q[r]),
			.p   (p),
			.v   (v[r]),
			.sat (row_sat[r])
		);
	end

	for (genvar l = 0; l < 3; l++) begin : g_div
		vtpd_div_lane u_div (
			.clk  (clk),
			.num  (v[l]),
			.den  (v[3]),
			.quot (q[l]),
			.sat  (q_sat[l])
		);
	end

	assign side_in.v      = v;
	assign side_in.sat    = |row_sat;
	assign side_in.div_en = (v[3] != '0) && (v[3] != ONE_Q16);

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-3:0], start & ~busy};
			done  <= vld_q[TOTAL_LAT-2];
		end
	end

	// merge: pick quotients or plain row sums
	always_ff @(posedge clk) begin
		if (side_q[DIV_LAT-1].div_en) begin
			out_x     <= q[0];
			out_y     <= q[1];
			out_z     <= q[2];
			out_w     <= ONE_Q16;
			divided   <= 1'b1;
			saturated <= side_q[DIV_LAT-1].sat | (|q_sat);
		end else begin
			out_x     <= side_q[DIV_LAT-1].v[0];
			out_y     <= side_q[DIV_LAT-1].v[1];
			out_z     <= side_q[DIV_LAT-1].v[2];
			out_w     <= side_q[DIV_LAT-1].v[3];
			divided   <= 1'b0;
			saturated <= side_q[DIV_LAT-1].sat;
		end
	end

endmodule

// ===== rtl/core/vtpd_row_lane.sv =====
// ----------------------------------------------------------------------------
// vtpd_row_lane
// One matrix row: four products, sum, round to Q16.16 and clamp.
// ----------------------------------------------------------------------------
module vtpd_row_lane (
	input  logic                      clk,
	input  logic [vtpd_pkg::ROW_W-1:0] row,
	input  vtpd_pkg::coord_t [3:0]    p,
	output vtpd_pkg::coord_t          v,
	output logic                      sat
);
	import vtpd_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-FRAC_SH-1:0] rnd;
	coord_t v_s2;
	logic   sat_s2;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			prod_s1[c] <= $signed(row[c*COEF_W +: COEF_W]) * p[c];
		end
	end

	always_comb begin
		acc = ACC_W'(prod_s1[0]) + ACC_W'(prod_s1[1]) + ACC_W'(prod_s1[2])
			+ ACC_W'(prod_s1[3]) + ACC_W'(2048);
		rnd = (ACC_W-FRAC_SH)'(acc >>> FRAC_SH);
	end

	always_ff @(posedge clk) begin
		if (rnd > (ACC_W-FRAC_SH)'(MAX_S32)) begin
			v_s2   <= MAX_S32;
			sat_s2 <= 1'b1;
		end else if (rnd < (ACC_W-FRAC_SH)'(MIN_S32)) begin
			v_s2   <= MIN_S32;
			sat_s2 <= 1'b1;
		end else begin
			v_s2   <= COORD_W'(rnd);
			sat_s2 <= 1'b0;
		end
	end

	assign v   = v_s2;
	assign sat = sat_s2;

endmodule

// ===== rtl/core/vtpd_div_lane.sv =====
// ----------------------------------------------------------------------------
// vtpd_div_lane
// Pipelined signed divide (v * 2^16) / w, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtpd_div_lane (
	input  logic             clk,
	input  vtpd_pkg::coord_t num,
	input  vtpd_pkg::coord_t den,
	output vtpd_pkg::coord_t quot,
	output logic             sat
);
	import vtpd_pkg::*;

	logic [COORD_W:0]   rem_q [QUOT_W+1];
	logic [QUOT_W-1:0]  dq_q  [QUOT_W+1];
	logic [COORD_W-1:0] d_q   [QUOT_W+1];
	logic               neg_q [QUOT_W+1];
	logic [COORD_W-1:0] num_mag, den_mag;
	coord_t quot_q;
	logic   sat_q;

	assign num_mag = num[COORD_W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[COORD_W-1] ? (~den + 1'b1) : den;

	always_ff @(posedge clk) begin
		rem_q[0] <= '0;
		dq_q[0]  <= {num_mag, 16'b0};
		d_q[0]   <= den_mag;
		neg_q[0] <= num[COORD_W-1] ^ den[COORD_W-1];
	end

	for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
		logic [COORD_W:0] t;
		logic             ge;
		assign t  = {rem_q[i][COORD_W-1:0], dq_q[i][QUOT_W-1]};
		assign ge = t >= {1'b0, d_q[i]};
		always_ff @(posedge clk) begin
			rem_q[i+1] <= ge ? (t - {1'b0, d_q[i]}) : t;
			dq_q[i+1]  <= {dq_q[i][QUOT_W-2:0], ge};
			d_q[i+1]   <= d_q[i];
			neg_q[i+1] <= neg_q[i];
		end
	end

	// magnitude to signed, clamped
	always_ff @(posedge clk) begin
		if (neg_q[QUOT_W]) begin
			if (dq_q[QUOT_W] > QUOT_W'(33'h1_0000_0000 >> 1)) begin
				quot_q <= MIN_S32;
				sat_q  <= 1'b1;
			end else begin
				quot_q <= COORD_W'(~dq_q[QUOT_W][COORD_W-1:0] + 1'b1);
				sat_q  <= 1'b0;
			end
		end else begin
			if (dq_q[QUOT_W][QUOT_W-1:COORD_W-1] != '0) begin
				quot_q <= MAX_S32;
				sat_q  <= 1'b1;
			end else begin
				quot_q <= COORD_W'(dq_q[QUOT_W][COORD_W-1:0]);
				sat_q  <= 1'b0;
			end
		end
	end

	assign quot = quot_q;
	assign sat  = sat_q;

endmodule

// ===== rtl/core/vtpd_checker.sv =====
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks on the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module vtpd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input vtpd_pkg::coord_t out_w,
	input logic             divided
);
	import vtpd_pkg::*;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(TOTAL_LAT) done)
		else $error("result missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result without transaction");

	a_div_w_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divided) |-> (out_w == ONE_Q16))
		else $error("w not 1.0 after divide");

	// no divide only when w came out as 0 or exactly 1.0
	a_nodiv_w: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !divided) |-> (out_w == '0 || out_w == ONE_Q16))
		else $error("w neither 0 nor 1.0 without divide");

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.out_w   (out_w),
	.divided (divided)
);
